/* rtl/ci1d_pkg.sv */
// ----------------------------------------------------------------------------
// ci1d_pkg: shared types and constants
// Field widths, store depth and register indexes of the 1-D cubic interpolator.
// ----------------------------------------------------------------------------
package ci1d_pkg;

   localparam int MaxSamples = 1024;
   localparam int AddrW      = $clog2(MaxSamples);
   localparam int CntW       = AddrW + 1;
   localparam int EntryW     = 33;

   localparam logic [1:0] REG_T_MIN    = 2'd0;
   localparam logic [1:0] REG_INV_STEP = 2'd1;
   localparam logic [1:0] REG_COUNT    = 2'd2;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // query stage data after position map
   typedef struct packed {
      logic             qok;
      logic [15:0]      frac;
      logic [AddrW-1:0] k0;
      logic [AddrW-1:0] k1;
      logic [AddrW-1:0] k2;
      logic [AddrW-1:0] k3;
   } pos_type;

   // saturate a signed value to 32 bits
   function automatic logic [31:0] sat32(input logic signed [39:0] v);
      logic [31:0] r;
      if (v > 40'sd2147483647) r = 32'h7FFF_FFFF;
      else if (v < -40'sd2147483648) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

/* rtl/ci1d_ram.sv */
// ----------------------------------------------------------------------------
// ci1d_ram: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ci1d_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

/* rtl/ci1d_posmap.sv */
// ----------------------------------------------------------------------------
// ci1d_posmap: query position map
// Two stages: difference times inv_step, then clamp and split to indexes.
// ----------------------------------------------------------------------------
module ci1d_posmap (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_vld,
   input  logic [31:0]             query_t,
   input  logic                    query_ok,
   input  logic [31:0]             t_min,
   input  logic [31:0]             inv_step,
   input  logic [ci1d_pkg::CntW-1:0] count,
   output logic                    out_vld,
   output ci1d_pkg::pos_type       out_pos
);
   import ci1d_pkg::*;

   logic        v1_ff, v1_in;
   logic        neg_ff, neg_in;
   logic        qok_ff;
   logic [63:0] prod_ff, prod_in;
   logic [CntW-1:0] n_ff, n_in;
   logic        v2_ff;
   pos_type     pos_ff, pos_in;

   logic signed [32:0] d;
   logic [32:0]        mag;

   always_comb begin
      d       = $signed({query_t[31], query_t}) - $signed({t_min[31], t_min});
      neg_in  = d[32];
      mag     = d[32] ? 33'(-d) : 33'(d);
      prod_in = 64'(mag) * 64'(inv_step);
      v1_in   = in_vld;
      if (count == '0) n_in = CntW'(1);
      else if (count > CntW'(MaxSamples)) n_in = CntW'(MaxSamples);
      else n_in = count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff  <= neg_in;
         prod_ff <= prod_in;
         qok_ff  <= query_ok;
         n_ff    <= n_in;
         pos_ff  <= pos_in;
      end
   end

   logic [63:0] three, top, pos;
   logic [CntW+1:0] ix;
   logic [CntW+1:0] kk [4];

   always_comb begin
      three = 64'd3 << 32;
      top   = 64'(n_ff + CntW'(5)) << 32;
      if (neg_ff) pos = (prod_ff >= three) ? 64'd0 : three - prod_ff;
      else        pos = (prod_ff >= top - three) ? top : prod_ff + three;
      ix = pos[32+CntW+1:32];
      pos_in.qok  = qok_ff;
      pos_in.frac = pos[31:16];
      for (int j = 0; j < 4; j++) begin
         if (ix + (CntW+2)'(j) < (CntW+2)'(4)) kk[j] = '0;
         else kk[j] = ix + (CntW+2)'(j) - (CntW+2)'(4);
         if (kk[j] > (CntW+2)'(n_ff) - (CntW+2)'(1)) kk[j] = (CntW+2)'(n_ff) - (CntW+2)'(1);
      end
      pos_in.k0 = kk[0][AddrW-1:0];
      pos_in.k1 = kk[1][AddrW-1:0];
      pos_in.k2 = kk[2][AddrW-1:0];
      pos_in.k3 = kk[3][AddrW-1:0];
   end

   assign out_vld = v2_ff;
   assign out_pos = pos_ff;
endmodule

/* rtl/ci1d_eval.sv */
// ----------------------------------------------------------------------------
// ci1d_eval: coefficient and Horner stages
// Forms doubled Catmull-Rom coefficients, runs Horner over three multiply
// stages; invalid samples give nearest, linear or (e1 invalid) no output.
// ----------------------------------------------------------------------------
module ci1d_eval (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_vld,
   input  logic        qok,
   input  logic [15:0] frac,
   input  logic [32:0] e0,
   input  logic [32:0] e1,
   input  logic [32:0] e2,
   input  logic [32:0] e3,
   output logic        out_vld,
   output logic [31:0] value,
   output logic        value_ok
);
   import ci1d_pkg::*;

   // mode: 0 invalid, 1 nearest, 2 linear, 3 cubic
   logic [1:0] mode_in;
   logic signed [36:0] c0_in, c1_in, c2_in, c3_in;
   logic signed [31:0] z0, z1, z2, z3;

   always_comb begin
      z0 = e0[31:0]; z1 = e1[31:0]; z2 = e2[31:0]; z3 = e3[31:0];
      if (!qok) mode_in = 2'd0;
      else if (!e1[32]) mode_in = 2'd0;
      else if (!e2[32]) mode_in = 2'd1;
      else if (!e0[32] || !e3[32]) mode_in = 2'd2;
      else mode_in = 2'd3;
      c0_in = 37'sd3 * (37'(z1) - 37'(z2)) + (37'(z3) - 37'(z0));
      c1_in = 37'sd2 * 37'(z0) - 37'sd5 * 37'(z1) + 37'sd4 * 37'(z2) - 37'(z3);
      c2_in = 37'(z2) - 37'(z0);
      c3_in = 37'sd2 * 37'(z1);
      if (mode_in == 2'd2) begin
         // linear: h = (z2-z1), add z1 after one multiply
         c0_in = 37'(z2) - 37'(z1);
         c1_in = 37'(z1);
      end
   end

   // stage A: coefficients registered
   logic              va_ff;
   logic [1:0]        ma_ff;
   logic [15:0]       xa_ff;
   logic signed [36:0] a0_ff, a1_ff, a2_ff, a3_ff;
   // stages B/C/D: one Horner step each
   logic              vb_ff, vc_ff, vd_ff;
   logic [1:0]        mb_ff, mc_ff, md_ff;
   logic [15:0]       xb_ff, xc_ff;
   logic signed [36:0] hb_ff, hc_ff, hd_ff;
   logic signed [36:0] b2_ff, b3_ff, cc3_ff;
   logic signed [36:0] hb_in, hc_in, hd_in;
   logic signed [53:0] pa, pb, pc;

   always_comb begin
      pa = 54'(a0_ff) * $signed({1'b0, xa_ff});
      hb_in = 37'(pa >>> 16) + a1_ff;
      pb = 54'(hb_ff) * $signed({1'b0, xb_ff});
      hc_in = 37'(pb >>> 16) + b2_ff;
      pc = 54'(hc_ff) * $signed({1'b0, xc_ff});
      hd_in = 37'(pc >>> 16) + cc3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0; vb_ff <= 1'b0; vc_ff <= 1'b0; vd_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_vld; vb_ff <= va_ff; vc_ff <= vb_ff; vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff <= mode_in; xa_ff <= frac;
         a0_ff <= c0_in; a1_ff <= c1_in; a2_ff <= c2_in; a3_ff <= c3_in;
         mb_ff <= ma_ff; xb_ff <= xa_ff; b2_ff <= a2_ff; b3_ff <= a3_ff;
         hb_ff <= (ma_ff == 2'd1) ? a3_ff : hb_in;
         mc_ff <= mb_ff; xc_ff <= xb_ff; cc3_ff <= b3_ff;
         hc_ff <= (mb_ff == 2'd3) ? hc_in : hb_ff;
         md_ff <= mc_ff;
         hd_ff <= (mc_ff == 2'd3) ? hd_in : hc_ff;
      end
   end

   logic signed [39:0] fin;
   always_comb begin
      case (md_ff)
         2'd3:    fin = 40'(hd_ff >>> 1);
         2'd0:    fin = '0;
         2'd1:    fin = 40'(hd_ff >>> 1);
         default: fin = 40'(hd_ff);
      endcase
   end

   assign out_vld  = vd_ff;
   assign value    = sat32(fin);
   assign value_ok = (md_ff != 2'd0);
endmodule

/* rtl/cubic_interpolator_1d.sv */
// ----------------------------------------------------------------------------
// cubic_interpolator_1d: Catmull-Rom cubic interpolation, Q16.16
// Sample store with load items, queries evaluated by a pipelined Horner chain.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries load or query transactions (req_tuser = kind).
//   Loads write one sample into the store and give no result; queries
//   give exactly one rsp_ transaction with the interpolated value.
//   csr_ writes t_min, inv_step and sample_count while idle.
// Pipeline: position map, RAM read, eval stages A-D, output register.
//   Throughput: one transaction per cycle unless the output is stalled;
//   the four sample reads use four RAM copies written together.
// Reset clears all pipeline valid bits and the registers to their defaults;
//   the store is undefined until loaded.
// Stall: the whole pipeline advances only when the output register is empty
//   or being taken, so a stalled receiver holds every stage in place and
//   req_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module cubic_interpolator_1d (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // sample_index[9:0], sample_value[41:10], sample_valid[42],
   // query_t[74:43], query_valid[75], zero pad
   input  logic [79:0] req_tdata,
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // interp_value[31:0], interp_valid[32], zero pad
   output logic [39:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import ci1d_pkg::*;

   logic [31:0]     t_min_ff, inv_step_ff;
   logic [CntW-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t_min_ff    <= '0;
         inv_step_ff <= 32'd65536;
         count_ff    <= CntW'(1);
      end else if (csr_we) begin
         case (csr_index)
            REG_T_MIN:    t_min_ff    <= csr_wdata;
            REG_INV_STEP: inv_step_ff <= csr_wdata;
            REG_COUNT:    count_ff    <= csr_wdata[CntW-1:0];
            default:      ;
         endcase
      end
   end

   logic en, acc, is_query, is_load;
   logic        out_vld_ff;
   logic [32:0] out_data_ff;

   assign en         = !out_vld_ff || rsp_tready;
   assign req_tready = en;
   assign acc        = req_tvalid && en;
   assign is_query   = acc && (req_tuser == KIND_QUERY);
   assign is_load    = acc && (req_tuser == KIND_LOAD);

   // loads write one stage late, so an earlier query still reads the old entry
   logic              ld_vld_ff;
   logic [AddrW-1:0]  ld_addr_ff;
   logic [EntryW-1:0] ld_data_ff;

   always_ff @(posedge clock) begin
      if (reset) ld_vld_ff <= 1'b0;
      else if (en) ld_vld_ff <= is_load;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         ld_addr_ff <= req_tdata[AddrW-1:0];
         ld_data_ff <= req_tdata[42:10];
      end
   end

   logic    pm_vld;
   pos_type pm_pos;

   ci1d_posmap u_posmap (
      .clock, .reset, .en,
      .in_vld(is_query), .query_t(req_tdata[74:43]), .query_ok(req_tdata[75]),
      .t_min(t_min_ff), .inv_step(inv_step_ff), .count(count_ff),
      .out_vld(pm_vld), .out_pos(pm_pos)
   );

   // RAM read stage: address held while stalled
   logic rd_vld_ff;
   logic qok_ff;
   logic [15:0] frac_ff;
   logic [32:0] e [4];
   logic [AddrW-1:0] ka [4];

   assign ka[0] = pm_pos.k0;
   assign ka[1] = pm_pos.k1;
   assign ka[2] = pm_pos.k2;
   assign ka[3] = pm_pos.k3;

   for (genvar g = 0; g < 4; g++) begin : g_ram
      ci1d_ram #(.Width(EntryW), .Depth(MaxSamples)) u_ram (
         .clock,
         .wr_en(ld_vld_ff && en),
         .wr_addr(ld_addr_ff),
         .wr_data(ld_data_ff),
         .rd_en(en),
         .rd_addr(ka[g]),
         .rd_data(e[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) rd_vld_ff <= 1'b0;
      else if (en) rd_vld_ff <= pm_vld;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         qok_ff  <= pm_pos.qok;
         frac_ff <= pm_pos.frac;
      end
   end

   logic        ev_vld, ev_ok;
   logic [31:0] ev_val;

   ci1d_eval u_eval (
      .clock, .reset, .en,
      .in_vld(rd_vld_ff), .qok(qok_ff), .frac(frac_ff),
      .e0(e[0]), .e1(e[1]), .e2(e[2]), .e3(e[3]),
      .out_vld(ev_vld), .value(ev_val), .value_ok(ev_ok)
   );

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (en) out_vld_ff <= ev_vld;
   end
   always_ff @(posedge clock) begin
      if (en) out_data_ff <= {ev_ok, ev_val};
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {7'd0, out_data_ff};
endmodule
